@@ sv/fir_correlator_2048_tap_macros.svh @@
// ----------------------------------------------------------------------------
// fir_correlator_2048_tap_macros - assertion macros
// Clocked concurrent assertion shorthands used by the correlator top level.
// ----------------------------------------------------------------------------
`ifndef FIR_CORRELATOR_2048_TAP_MACROS_SVH
`define FIR_CORRELATOR_2048_TAP_MACROS_SVH

// checked outside reset
`define FCOR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define FCOR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/fcor_pkg.sv @@
// ----------------------------------------------------------------------------
// fcor_pkg - correlator shared definitions
// Field widths, item modes, sequencer states and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package fcor_pkg;

    localparam int VALUE_W   = 16;
    localparam int COEF_W    = 16;
    localparam int INDEX_W   = 11;
    localparam int ADDR_W    = 12;  // covers the largest tap count
    localparam int RESULT_W  = 43;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam logic MODE_COEF = 1'b0;
    localparam logic MODE_PUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                     smp_shift;
        logic                     coef_shift;
        logic                     coef_we;
        logic [ADDR_W-1:0]        coef_addr;
        logic signed [COEF_W-1:0] coef_val;
    } cell_ctrl_t;

    typedef struct packed {
        logic en;
        logic clr;
    } mac_ctrl_t;

endpackage

`default_nettype wire

@@ sv/fcor_cell.sv @@
// ----------------------------------------------------------------------------
// fcor_cell - one tap cell
// Holds one window sample and one coefficient; both shift toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module fcor_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int CELL_IDX    = 0
) (
    input  wire logic                              aclk,
    input  wire fcor_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]     smp_in,
    input  wire logic signed [fcor_pkg::COEF_W-1:0] coef_in,
    output logic signed [SAMPLE_BITS-1:0]          smp_out,
    output logic signed [fcor_pkg::COEF_W-1:0]     coef_out
);

    logic signed [SAMPLE_BITS-1:0]      smp_reg;
    logic signed [fcor_pkg::COEF_W-1:0] coef_reg;
    logic                               hit;

    assign hit = ctrl.coef_we && (ctrl.coef_addr == fcor_pkg::ADDR_W'(CELL_IDX));

    always_ff @(posedge aclk) begin
        if (ctrl.smp_shift) begin
            smp_reg <= smp_in;
        end
        if (ctrl.coef_shift) begin
            coef_reg <= coef_in;
        end else if (hit) begin
            coef_reg <= ctrl.coef_val;
        end
    end

    assign smp_out  = smp_reg;
    assign coef_out = coef_reg;

endmodule

`default_nettype wire

@@ sv/fcor_mac.sv @@
// ----------------------------------------------------------------------------
// fcor_mac - head multiply-accumulate
// Registered product of the head cell pair, summed exactly into the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fcor_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire fcor_pkg::mac_ctrl_t                 ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]       smp,
    input  wire logic signed [fcor_pkg::COEF_W-1:0]  coef,
    output logic signed [fcor_pkg::RESULT_W-1:0]     acc
);

    localparam int PROD_W = SAMPLE_BITS + fcor_pkg::COEF_W;

    logic signed [PROD_W-1:0]             prod_reg;
    logic                                 prod_vld_reg;
    logic signed [fcor_pkg::RESULT_W-1:0] acc_reg;
    logic signed [fcor_pkg::RESULT_W-1:0] acc_next;
    logic signed [fcor_pkg::RESULT_W-1:0] prod_ext;

    assign prod_ext = {{(fcor_pkg::RESULT_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clr) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + prod_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(smp) * PROD_W'(coef);
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

@@ sv/fir_correlator_2048_tap.sv @@
// ----------------------------------------------------------------------------
// fir_correlator_2048_tap - FIR correlator over a chain of tap cells
//
// channel  dir  beat contents
// s_*      in   tuser: mode | tdata: coef_index [10:0], value [26:11]
// m_*      out  tdata: result [42:0]
//
// Coefficient writes and pushes that leave the window short of TAPS are
// taken in idle. A push that fills or finds a full window starts a pass:
// the cell ring rotates TAPS times past one multiplier at the head, and no
// beat is taken until the result is registered. Reset needs no clearing
// pass. A result waiting on m_tready stalls only the end of the next pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fir_correlator_2048_tap_macros.svh"

module fir_correlator_2048_tap #(
    parameter int TAPS        = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fcor_pkg::S_TDATA_W-1:0]   s_tdata,  // coef_index, value
    input  wire logic                             s_tuser,  // mode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [fcor_pkg::M_TDATA_W-1:0]        m_tdata   // result
);

    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int EXT_W  = (SAMPLE_BITS > fcor_pkg::VALUE_W) ? SAMPLE_BITS
                                                              : fcor_pkg::VALUE_W;

    fcor_pkg::state_t state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic signed [fcor_pkg::RESULT_W-1:0] out_reg;

    logic                                 beat_in;
    logic                                 push;
    logic                                 cwr;
    logic                                 start;
    logic                                 last;
    logic                                 out_ok;
    logic                                 load_out;
    logic [fcor_pkg::INDEX_W-1:0]         idx_in;
    logic [fcor_pkg::VALUE_W-1:0]         val_in;
    logic [EXT_W-1:0]                     val_ext;
    logic signed [SAMPLE_BITS-1:0]        new_smp;
    logic signed [SAMPLE_BITS-1:0]        tail_smp;
    logic signed [fcor_pkg::RESULT_W-1:0] acc;

    fcor_pkg::cell_ctrl_t cell_ctrl;
    fcor_pkg::mac_ctrl_t  mac_ctrl;

    logic signed [SAMPLE_BITS-1:0]      smp_q  [TAPS];
    logic signed [fcor_pkg::COEF_W-1:0] coef_q [TAPS];

    assign idx_in  = s_tdata[fcor_pkg::INDEX_W-1:0];
    assign val_in  = s_tdata[fcor_pkg::INDEX_W +: fcor_pkg::VALUE_W];
    assign val_ext = EXT_W'(val_in);
    assign new_smp = val_ext[SAMPLE_BITS-1:0];

    assign beat_in = s_tvalid && s_tready;
    assign push    = beat_in && (s_tuser == fcor_pkg::MODE_PUSH);
    assign cwr     = beat_in && (s_tuser == fcor_pkg::MODE_COEF);
    assign start   = push && (fill_reg >= FILL_W'(TAPS - 1));
    assign last    = (cnt_reg == CNT_W'(TAPS - 1));
    assign out_ok  = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fcor_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = fcor_pkg::ST_RUN;
                end
            end
            fcor_pkg::ST_RUN: begin
                if (last) begin
                    state_next = fcor_pkg::ST_FLUSH;
                end
            end
            fcor_pkg::ST_FLUSH: begin
                state_next = fcor_pkg::ST_DONE;
            end
            fcor_pkg::ST_DONE: begin
                if (out_ok) begin
                    state_next = fcor_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fcor_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready             = 1'b0;
        load_out             = 1'b0;
        cell_ctrl.smp_shift  = push;
        cell_ctrl.coef_shift = 1'b0;
        cell_ctrl.coef_we    = cwr;
        cell_ctrl.coef_addr  = fcor_pkg::ADDR_W'(idx_in);
        cell_ctrl.coef_val   = val_in;
        mac_ctrl.en          = 1'b0;
        mac_ctrl.clr         = start;
        case (state_reg)
            fcor_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            fcor_pkg::ST_RUN: begin
                cell_ctrl.smp_shift  = 1'b1;
                cell_ctrl.coef_shift = 1'b1;
                mac_ctrl.en          = 1'b1;
            end
            fcor_pkg::ST_FLUSH: begin
                load_out = 1'b0;
            end
            fcor_pkg::ST_DONE: begin
                load_out = out_ok;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        if (push && (fill_reg != FILL_W'(TAPS))) begin
            fill_next = fill_reg + 1'b1;
        end
        cnt_next = (state_reg == fcor_pkg::ST_RUN) ? cnt_reg + 1'b1 : '0;
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fcor_pkg::ST_IDLE;
            fill_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= acc;
        end
    end

    // ring: head wraps to tail while rotating, new sample enters on push
    assign tail_smp = (state_reg == fcor_pkg::ST_RUN) ? smp_q[0] : new_smp;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        fcor_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CELL_IDX    (k)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .smp_in   ((k == TAPS - 1) ? tail_smp  : smp_q[(k + 1) % TAPS]),
            .coef_in  ((k == TAPS - 1) ? coef_q[0] : coef_q[(k + 1) % TAPS]),
            .smp_out  (smp_q[k]),
            .coef_out (coef_q[k])
        );
    end

    fcor_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .smp     (smp_q[0]),
        .coef    (coef_q[0]),
        .acc     (acc)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(fcor_pkg::M_TDATA_W - fcor_pkg::RESULT_W){1'b0}}, out_reg};

    `FCOR_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FILL_W'(TAPS), "fill count past TAPS")
    `FCOR_ASSERT(a_run_full, aclk, aresetn, (state_reg == fcor_pkg::ST_RUN) |-> (fill_reg == FILL_W'(TAPS)), "pass with short window")
    `FCOR_ASSERT(a_run_len, aclk, aresetn, (state_reg == fcor_pkg::ST_RUN && last) |=> (state_reg == fcor_pkg::ST_FLUSH), "pass did not end after TAPS rotations")
    `FCOR_ASSERT(a_hold_done, aclk, aresetn, (state_reg == fcor_pkg::ST_DONE && m_tvalid && !m_tready) |=> (state_reg == fcor_pkg::ST_DONE), "result overwrote a pending beat")
    `FCOR_ASSERT(a_start_cnt, aclk, aresetn, start |=> (cnt_reg == '0), "pass started with nonzero count")
    `FCOR_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> (state_reg == fcor_pkg::ST_IDLE && !m_tvalid), "reset did not clear control")

endmodule

`default_nettype wire

@@ bench/fcor_sum_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcor_sum_checker - correlator result checker
// Follows coefficient writes and sample pushes on the input channel, keeps
// its own tap bank and sample ring, computes the exact dot product of every
// full window and matches result beats against those sums in order.
// ----------------------------------------------------------------------------
module fcor_sum_checker #(
    parameter int TAPS = 2048
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [fcor_pkg::S_TDATA_W-1:0] s_tdata,  // coef_index, value
    input  logic                           s_tuser,  // mode
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [fcor_pkg::M_TDATA_W-1:0] m_tdata,  // result
    output int                             fail_count,
    output int                             sums_pending
);

    localparam int INDEX_W  = fcor_pkg::INDEX_W;
    localparam int VALUE_W  = fcor_pkg::VALUE_W;
    localparam int RESULT_W = fcor_pkg::RESULT_W;

    logic signed [VALUE_W-1:0]  coef_bank [TAPS];
    logic signed [VALUE_W-1:0]  sample_ring [TAPS];
    int unsigned                ring_wr;
    int unsigned                ring_fill;
    logic signed [RESULT_W-1:0] expected_sums [$];

    initial begin
        fail_count   = 0;
        sums_pending = 0;
    end

    // ring_wr points at the oldest sample once the ring is full
    function automatic logic signed [RESULT_W-1:0] window_dot_product();
        longint      acc;
        int unsigned pos;
        acc = 0;
        pos = ring_wr;
        for (int i = 0; i < TAPS; i++) begin
            acc += longint'(sample_ring[pos]) * longint'(coef_bank[i]);
            pos = (pos + 1) % TAPS;
        end
        return acc[RESULT_W-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        logic [INDEX_W-1:0]         idx;
        logic signed [VALUE_W-1:0]  val;
        logic signed [RESULT_W-1:0] got;
        logic signed [RESULT_W-1:0] want;
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                sample_ring[i] = '0;
                coef_bank[i]   = '0;
            end
            ring_wr   = 0;
            ring_fill = 0;
            expected_sums.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_W-1:0];
                if (expected_sums.size() == 0) begin
                    $error("result: expected none, actual %0d", got);
                    fail_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (got !== want) begin
                        $error("result: expected %0d, actual %0d", want, got);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                idx = s_tdata[INDEX_W-1:0];
                val = s_tdata[INDEX_W +: VALUE_W];
                if (s_tuser == fcor_pkg::MODE_COEF) begin
                    if (idx < TAPS)
                        coef_bank[idx] = val;
                end else begin
                    sample_ring[ring_wr] = val;
                    ring_wr = (ring_wr + 1) % TAPS;
                    if (ring_fill < TAPS)
                        ring_fill++;
                    if (ring_fill == TAPS)
                        expected_sums.push_back(window_dot_product());
                end
            end
        end
        sums_pending <= expected_sums.size();
    end

endmodule

@@ bench/fir_correlator_2048_tap_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir_correlator_2048_tap_tb - correlator regression
// Loads every tap, fills the sample window, runs directed extremes and then
// a random mix of coefficient rewrites and sample pushes with random gaps on
// the input and random stalls on the output; the checker scores each result.
// ----------------------------------------------------------------------------
module fir_correlator_2048_tap_tb;

    localparam int     TAPS         = 2048;
    localparam int     PASS_CYCLES  = TAPS + 3;
    localparam int     RANDOM_ITEMS = 1600;
    localparam longint CYCLE_LIMIT  = 40_000_000;

    localparam logic [fcor_pkg::VALUE_W-1:0] VAL_MIN  = 16'h8000;
    localparam logic [fcor_pkg::VALUE_W-1:0] VAL_MAX  = 16'h7FFF;
    localparam logic [fcor_pkg::VALUE_W-1:0] VAL_ZERO = 16'h0000;
    localparam logic [fcor_pkg::VALUE_W-1:0] VAL_NEG1 = 16'hFFFF;
    localparam logic [fcor_pkg::VALUE_W-1:0] VAL_ONE  = 16'h0001;
    localparam logic [fcor_pkg::INDEX_W-1:0] IDX_LAST = fcor_pkg::INDEX_W'(TAPS - 1);

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [fcor_pkg::S_TDATA_W-1:0] s_tdata  = '0;  // coef_index [10:0], value [26:11]
    logic                           s_tuser  = fcor_pkg::MODE_COEF;  // mode
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [fcor_pkg::M_TDATA_W-1:0] m_tdata;        // result [42:0]

    int     fail_count;
    int     sums_pending;
    longint cycle_count = 0;
    int     send_calm   = 0;
    int     ready_hold  = 0;

    fir_correlator_2048_tap #(
        .TAPS(TAPS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fcor_sum_checker #(
        .TAPS(TAPS)
    ) sum_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .sums_pending (sums_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output backpressure: mostly short stalls, a few longer than a pass
    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            if (r < 70)
                ready_hold <= $urandom_range(0, 3);
            else if (r < 95)
                ready_hold <= $urandom_range(4, 60);
            else
                ready_hold <= $urandom_range(800, 4000);
        end else begin
            m_tready <= 1'b1;
            if (r < 10)
                ready_hold <= $urandom_range(2000, 6000);
            else
                ready_hold <= $urandom_range(1, 400);
        end
    end

    function automatic int sender_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            send_calm = $urandom_range(20, 150);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [fcor_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return VAL_ZERO;
            3:       return VAL_NEG1;
            default: return fcor_pkg::VALUE_W'($urandom());
        endcase
    endfunction

    function automatic logic [fcor_pkg::INDEX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return IDX_LAST;
            default: return fcor_pkg::INDEX_W'($urandom_range(0, TAPS - 1));
        endcase
    endfunction

    task automatic send_beat(input logic mode, input logic [fcor_pkg::INDEX_W-1:0] idx,
                             input logic [fcor_pkg::VALUE_W-1:0] val);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(fcor_pkg::S_TDATA_W - fcor_pkg::INDEX_W - fcor_pkg::VALUE_W){1'b0}},
                     val, idx};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sums_pending != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic mode;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every tap at the most negative value, window one short of full
        for (int i = 0; i < TAPS; i++)
            send_beat(fcor_pkg::MODE_COEF, fcor_pkg::INDEX_W'(i), VAL_MIN);
        for (int i = 0; i < TAPS - 1; i++)
            send_beat(fcor_pkg::MODE_PUSH, pick_index(), VAL_MIN);

        // largest positive sum, then edge taps and edge samples
        send_beat(fcor_pkg::MODE_PUSH, '0, VAL_MIN);
        send_beat(fcor_pkg::MODE_PUSH, IDX_LAST, VAL_MAX);
        send_beat(fcor_pkg::MODE_COEF, '0, VAL_MAX);
        send_beat(fcor_pkg::MODE_COEF, IDX_LAST, VAL_MAX);
        send_beat(fcor_pkg::MODE_COEF, fcor_pkg::INDEX_W'(TAPS / 2), VAL_ZERO);
        send_beat(fcor_pkg::MODE_PUSH, '0, VAL_ZERO);
        send_beat(fcor_pkg::MODE_PUSH, IDX_LAST, VAL_NEG1);
        send_beat(fcor_pkg::MODE_PUSH, '0, VAL_ONE);
        send_beat(fcor_pkg::MODE_COEF, IDX_LAST, VAL_NEG1);
        send_beat(fcor_pkg::MODE_COEF, '0, VAL_ONE);
        send_beat(fcor_pkg::MODE_PUSH, IDX_LAST, VAL_MAX);
        send_beat(fcor_pkg::MODE_COEF, 11'h555, 16'h5555);
        send_beat(fcor_pkg::MODE_COEF, 11'h2AA, 16'hAAAA);
        send_beat(fcor_pkg::MODE_PUSH, 11'h2AA, 16'h5555);
        send_beat(fcor_pkg::MODE_PUSH, 11'h555, 16'hAAAA);
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 400 == 399)
                wait_for_results();
            mode = ($urandom_range(0, 3) == 0) ? fcor_pkg::MODE_PUSH : fcor_pkg::MODE_COEF;
            send_beat(mode, pick_index(), pick_value());
        end

        wait_for_results();
        repeat (PASS_CYCLES + 16) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/fcor_pkg.sv
sv/fcor_cell.sv
sv/fcor_mac.sv
sv/fir_correlator_2048_tap.sv
bench/fcor_sum_checker.sv
bench/fir_correlator_2048_tap_tb.sv
